@@ rtl/iop_pkg.sv @@
// Shared types, message codes and helpers for the ITCH order message parser.
`timescale 1ns / 1ps
package iop_pkg;

  localparam int COUNT_LIMIT_DEF = 63;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_S = 8'h53;

  localparam logic [7:0] LEN_A = 8'd36;
  localparam logic [7:0] LEN_F = 8'd40;
  localparam logic [7:0] LEN_E = 8'd31;
  localparam logic [7:0] LEN_C = 8'd36;
  localparam logic [7:0] LEN_X = 8'd23;
  localparam logic [7:0] LEN_D = 8'd19;
  localparam logic [7:0] LEN_U = 8'd35;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_LENGTH = 3'd2,
    ST_SIDE   = 3'd3,
    ST_TYPE   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    EV_ADD     = 3'd0,
    EV_EXECUTE = 3'd1,
    EV_CANCEL  = 3'd2,
    EV_DELETE  = 3'd3,
    EV_REPLACE = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
    logic       empty_frame;
  } in_word_t;

  typedef struct packed {
    logic        pad;
    logic [31:0] price;
    logic [31:0] quantity;
    logic        sell_side;
    logic [63:0] new_order_number;
    logic [63:0] order_number;
    logic [47:0] timestamp;
    logic [15:0] locate_id;
    kind_t       event_kind;
    status_t     status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic in_span(input logic [7:0] pos, input logic [7:0] first,
                                   input logic [7:0] last);
    in_span = (pos >= first) && (pos <= last);
  endfunction

endpackage

@@ rtl/iop_in_stage.sv @@
// Input register stage for the incoming message byte stream.
`timescale 1ns / 1ps
module iop_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              in_tuser,
  output logic              word_valid,
  output iop_pkg::in_word_t word,
  input  logic              word_take
);
  import iop_pkg::*;

  logic     valid_r, valid_nxt;
  in_word_t word_r;

  assign in_tready = !valid_r || word_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      word_r <= '{byte_value: in_tdata, last_byte: in_tlast, empty_frame: in_tuser};
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

@@ rtl/iop_frame.sv @@
// Frame accumulator: gathers fields by byte offset and builds the result at frame end.
`timescale 1ns / 1ps
module iop_frame #(
  parameter int COUNT_LIMIT = iop_pkg::COUNT_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               word_valid,
  input  iop_pkg::in_word_t  word,
  output logic               word_take,
  input  logic               res_free,
  output logic               res_valid,
  output iop_pkg::result_t   res
);
  import iop_pkg::*;

  localparam int CW = $clog2(COUNT_LIMIT + 1);

  logic [CW-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]    type_code_r, type_code_nxt;
  logic [15:0]   locate_r, locate_nxt;
  logic [47:0]   time_r, time_nxt;
  logic [63:0]   order_r, order_nxt;
  logic [63:0]   new_order_r, new_order_nxt;
  logic [7:0]    side_r, side_nxt;
  logic [31:0]   qty_r, qty_nxt;
  logic [31:0]   price_r, price_nxt;

  logic       ends;
  logic [7:0] pos;
  logic [7:0] b;
  logic       is_add, is_exec, is_repl;
  logic [7:0] need;
  logic       known, has_qty, has_price;
  kind_t      kind;
  result_t    res_c;

  assign ends      = word.last_byte || word.empty_frame;
  assign word_take = word_valid && (!ends || res_free);
  assign res_valid = word_take && ends;
  assign pos       = 8'(byte_count_r);
  assign b         = word.byte_value;
  assign is_add    = (type_code_r == CH_A) || (type_code_r == CH_F);
  assign is_exec   = (type_code_r == CH_E) || (type_code_r == CH_C) || (type_code_r == CH_X);
  assign is_repl   = (type_code_r == CH_U);

  always_comb begin
    byte_count_nxt = byte_count_r;
    type_code_nxt  = type_code_r;
    locate_nxt     = locate_r;
    time_nxt       = time_r;
    order_nxt      = order_r;
    new_order_nxt  = new_order_r;
    side_nxt       = side_r;
    qty_nxt        = qty_r;
    price_nxt      = price_r;
    if (byte_count_r < CW'(COUNT_LIMIT)) begin
      byte_count_nxt = byte_count_r + CW'(1);
      if (pos == 8'd0) begin
        type_code_nxt = b;
      end else begin
        if (in_span(pos, 8'd1, 8'd2))   locate_nxt = {locate_r[7:0], b};
        if (in_span(pos, 8'd5, 8'd10))  time_nxt   = {time_r[39:0], b};
        if (in_span(pos, 8'd11, 8'd18)) order_nxt  = {order_r[55:0], b};
        if (is_add) begin
          if (pos == 8'd19)               side_nxt  = b;
          if (in_span(pos, 8'd20, 8'd23)) qty_nxt   = {qty_r[23:0], b};
          if (in_span(pos, 8'd32, 8'd35)) price_nxt = {price_r[23:0], b};
        end else if (is_exec) begin
          if (in_span(pos, 8'd19, 8'd22)) qty_nxt   = {qty_r[23:0], b};
        end else if (is_repl) begin
          if (in_span(pos, 8'd19, 8'd26)) new_order_nxt = {new_order_r[55:0], b};
          if (in_span(pos, 8'd27, 8'd30)) qty_nxt       = {qty_r[23:0], b};
          if (in_span(pos, 8'd31, 8'd34)) price_nxt     = {price_r[23:0], b};
        end
      end
    end
  end

  always_comb begin
    need      = LEN_A;
    kind      = EV_ADD;
    known     = 1'b1;
    has_qty   = 1'b1;
    has_price = 1'b0;
    unique case (type_code_nxt)
      CH_A: begin need = LEN_A; kind = EV_ADD; has_price = 1'b1; end
      CH_F: begin need = LEN_F; kind = EV_ADD; has_price = 1'b1; end
      CH_E: begin need = LEN_E; kind = EV_EXECUTE; end
      CH_C: begin need = LEN_C; kind = EV_EXECUTE; end
      CH_X: begin need = LEN_X; kind = EV_CANCEL; end
      CH_D: begin need = LEN_D; kind = EV_DELETE; has_qty = 1'b0; end
      CH_U: begin need = LEN_U; kind = EV_REPLACE; has_price = 1'b1; end
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    res_c = '0;
    if (word.empty_frame) begin
      res_c.status = ST_EMPTY;
    end else if (!known) begin
      res_c.status = ST_TYPE;
    end else if (8'(byte_count_nxt) != need) begin
      res_c.status = ST_LENGTH;
    end else if (kind == EV_ADD && side_nxt != CH_B && side_nxt != CH_S) begin
      res_c.status = ST_SIDE;
    end else begin
      res_c.status           = ST_OK;
      res_c.event_kind       = kind;
      res_c.locate_id        = locate_nxt;
      res_c.timestamp        = time_nxt;
      res_c.order_number     = order_nxt;
      res_c.new_order_number = (kind == EV_REPLACE) ? new_order_nxt : 64'd0;
      res_c.sell_side        = (kind == EV_ADD) && (side_nxt == CH_S);
      res_c.quantity         = has_qty ? qty_nxt : 32'd0;
      res_c.price            = has_price ? price_nxt : 32'd0;
    end
  end

  assign res = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n || (word_take && ends)) begin
      byte_count_r <= '0;
      type_code_r  <= '0;
      locate_r     <= '0;
      time_r       <= '0;
      order_r      <= '0;
      new_order_r  <= '0;
      side_r       <= '0;
      qty_r        <= '0;
      price_r      <= '0;
    end else if (word_take) begin
      byte_count_r <= byte_count_nxt;
      type_code_r  <= type_code_nxt;
      locate_r     <= locate_nxt;
      time_r       <= time_nxt;
      order_r      <= order_nxt;
      new_order_r  <= new_order_nxt;
      side_r       <= side_nxt;
      qty_r        <= qty_nxt;
      price_r      <= price_nxt;
    end
  end

endmodule

@@ rtl/iop_out_stage.sv @@
// Output register holding one parsed result until the downstream side takes it.
`timescale 1ns / 1ps
module iop_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_valid,
  input  iop_pkg::result_t                  res,
  output logic                              res_free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [iop_pkg::RESULT_W-1:0]      out_tdata
);
  import iop_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign res_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_free) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

@@ rtl/itch_order_message_parser.sv @@
// Top level of the ITCH order message parser.
`timescale 1ns / 1ps
// Takes one message byte per cycle with no gaps needed between frames; the result of a
// frame is loaded into the output register, raising out_tvalid, when its last byte leaves
// the input register, since the fields are decoded combinationally between the two registers.
// in_tready falls only while a finished result is held by a stalled output and the word
// waiting in the input register ends a frame.
module itch_order_message_parser #(
  parameter int COUNT_LIMIT = iop_pkg::COUNT_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // byte_value
  input  logic                         in_tlast,
  input  logic                         in_tuser,   // empty_frame
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status, event_kind, locate_id, timestamp, order_number, new_order_number,
  // sell_side, quantity, price, one zero pad bit
  output logic [iop_pkg::RESULT_W-1:0] out_tdata
);
  import iop_pkg::*;

  logic     word_valid, word_take;
  in_word_t word;
  logic     res_valid, res_free;
  result_t  res;

  iop_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  iop_frame #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  iop_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_free   (res_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
